// ----- sv/dqp_pkg.sv -----
// shared types and constants for the dct quantizer with prediction
// used by dqp_cell, dqp_out_stage and dct_quantizer_with_prediction
`default_nettype none

package dqp_pkg;

	// fixed field widths
	localparam int FIELD_W = 16;
	localparam int IDX_W   = 6;
	localparam int STEP_W  = 15;
	localparam int SEL_W   = 2;

	// divider: numerator is 2|c| + s (17 bits), divisor 2s (16 bits),
	// quotient never exceeds 32768, so 16 quotient bits, one per cell
	localparam int DIVW = 16;

	// defaults for the top level parameters
	localparam int NUM_DC_PREDICTORS_DEF = 3;
	localparam int COEF_WIDTH_DEF        = 16;

	// side information that rides along with the division
	typedef struct packed {
		logic               kind;
		logic               is_dc;
		logic [SEL_W-1:0]   sel;
		logic               neg;
		logic               zero_step;
		logic               coef_zero;
		logic [FIELD_W-1:0] prev_ref;
	} dqp_side_t;

	// one word handed from cell to cell
	typedef struct packed {
		logic [DIVW-1:0] rem;
		logic [DIVW-1:0] num;
		logic [DIVW-1:0] quo;
		logic [DIVW-1:0] div;
		dqp_side_t       side;
	} dqp_word_t;

endpackage

`default_nettype wire

// ----- sv/dct_quantizer_with_prediction.sv -----
// top level of the dct quantizer with dc and inter-frame prediction
// depends on dqp_pkg, dqp_cell and dqp_out_stage
// pipeline: an accepted word is loaded into the first of 16 division cells, then passes
// through the rest and one output stage before its result is valid; stalls hold it back
// throughput: one word per cycle, back to back, while out_ready is high; each cell is elastic
// reset: arst_n clears all valid flags and the dc predictors, nothing else
`default_nettype none

module dct_quantizer_with_prediction #(
	parameter int NUM_DC_PREDICTORS = dqp_pkg::NUM_DC_PREDICTORS_DEF,
	parameter int COEF_WIDTH        = dqp_pkg::COEF_WIDTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire [0:0]                           kind,
	input  wire [dqp_pkg::IDX_W-1:0]            coef_index,
	input  wire signed [dqp_pkg::FIELD_W-1:0]   coefficient,
	input  wire [dqp_pkg::STEP_W-1:0]           quant_step,
	input  wire [dqp_pkg::SEL_W-1:0]            predictor_sel,
	input  wire signed [dqp_pkg::FIELD_W-1:0]   previous_reference,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [dqp_pkg::FIELD_W-1:0]  coded_value,
	output logic signed [dqp_pkg::FIELD_W-1:0]  reference_value
);
	import dqp_pkg::*;

	// word chain: index k feeds cell k, index DIVW feeds the output stage
	dqp_word_t chain_word  [DIVW+1];
	logic      chain_valid [DIVW+1];
	logic      chain_ready [DIVW+1];

	logic [DIVW-1:0] mag;
	logic [DIVW:0]   numer;

	// rounding half away from zero: q = floor((2|c| + s) / (2s))
	always_comb begin
		mag   = coefficient[FIELD_W-1] ? DIVW'(-coefficient) : DIVW'(coefficient);
		numer = {mag, 1'b0} + (DIVW+1)'(quant_step);

		chain_word[0].rem            = DIVW'(numer[DIVW]);
		chain_word[0].num            = numer[DIVW-1:0];
		chain_word[0].quo            = '0;
		chain_word[0].div            = {quant_step, 1'b0};
		chain_word[0].side.kind      = kind[0];
		chain_word[0].side.is_dc     = coef_index == '0;
		chain_word[0].side.sel       = predictor_sel;
		chain_word[0].side.neg       = coefficient[FIELD_W-1];
		chain_word[0].side.zero_step = quant_step == '0;
		chain_word[0].side.coef_zero = coefficient == '0;
		chain_word[0].side.prev_ref  = previous_reference;
	end

	assign chain_valid[0] = in_valid;
	assign in_ready       = chain_ready[0];

	// one cell per quotient bit, most significant first
	for (genvar k = 0; k < DIVW; k++) begin : g_cell
		dqp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[k]),
			.up_ready (chain_ready[k]),
			.up_word  (chain_word[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_ready (chain_ready[k+1]),
			.dn_word  (chain_word[k+1])
		);
	end

	// sign, saturation, prediction and the result register
	dqp_out_stage #(
		.NUM_DC_PREDICTORS (NUM_DC_PREDICTORS),
		.COEF_WIDTH        (COEF_WIDTH)
	) u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (chain_valid[DIVW]),
		.in_ready        (chain_ready[DIVW]),
		.in_word         (chain_word[DIVW]),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.coded_value     (coded_value),
		.reference_value (reference_value)
	);

endmodule

`default_nettype wire

// ----- sv/dqp_cell.sv -----
// one restoring division cell: produces one quotient bit per word
// depends on dqp_pkg
`default_nettype none

module dqp_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   up_valid,
	output logic                  up_ready,
	input  dqp_pkg::dqp_word_t    up_word,
	output logic                  dn_valid,
	input  wire                   dn_ready,
	output dqp_pkg::dqp_word_t    dn_word
);
	import dqp_pkg::*;

	logic              valid_q;
	dqp_word_t         word_q;
	dqp_word_t         word_nx;
	logic [DIVW:0]     trial;
	logic              ge;

	// bring down the next numerator bit and try the subtract
	always_comb begin
		trial   = {up_word.rem, up_word.num[DIVW-1]};
		ge      = trial >= {1'b0, up_word.div};
		word_nx = up_word;
		word_nx.rem = ge ? DIVW'(trial - {1'b0, up_word.div}) : trial[DIVW-1:0];
		word_nx.num = {up_word.num[DIVW-2:0], 1'b0};
		word_nx.quo = {up_word.quo[DIVW-2:0], ge};
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			word_q <= word_nx;
		end
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;

endmodule

`default_nettype wire

// ----- sv/dqp_out_stage.sv -----
// output stage: sign, saturation, dc and inter-frame prediction, result register
// depends on dqp_pkg; holds the dc predictor registers
`default_nettype none

module dqp_out_stage #(
	parameter int NUM_DC_PREDICTORS = dqp_pkg::NUM_DC_PREDICTORS_DEF,
	parameter int COEF_WIDTH        = dqp_pkg::COEF_WIDTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  dqp_pkg::dqp_word_t                in_word,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic signed [dqp_pkg::FIELD_W-1:0] coded_value,
	output logic signed [dqp_pkg::FIELD_W-1:0] reference_value
);
	import dqp_pkg::*;

	localparam int XW0  = (COEF_WIDTH > DIVW + 1) ? COEF_WIDTH : DIVW + 1;
	localparam int XW   = XW0 + 1;
	localparam int CW0  = $clog2(NUM_DC_PREDICTORS + 1);
	localparam int SELX = (CW0 > SEL_W) ? CW0 : SEL_W;

	logic                                          out_valid_q;
	logic signed [FIELD_W-1:0]                     coded_q;
	logic signed [FIELD_W-1:0]                     ref_q;
	logic                                          kind_q;
	logic                                          dc_q;
	logic [NUM_DC_PREDICTORS-1:0][COEF_WIDTH-1:0]  pred_q;

	logic                          load;
	logic signed [XW-1:0]          q_pos;
	logic signed [XW-1:0]          q_val;
	logic signed [XW-1:0]          sat_hi;
	logic signed [XW-1:0]          sat_lo;
	logic signed [XW-1:0]          q_sat;
	logic signed [COEF_WIDTH-1:0]  q_cw;
	logic signed [XW-1:0]          prev_ext;
	logic signed [COEF_WIDTH-1:0]  prev_cw;
	logic signed [COEF_WIDTH-1:0]  pred_rd;
	logic                          pred_ok;
	logic                          pred_wr;
	logic signed [COEF_WIDTH-1:0]  coded_cw;
	logic signed [XW-1:0]          coded_ext;
	logic signed [XW-1:0]          q_ext;

	assign in_ready = !out_valid_q || out_ready;
	assign load     = in_valid && in_ready;

	always_comb begin
		sat_hi = (XW'(1) <<< (COEF_WIDTH - 1)) - XW'(1);
		sat_lo = -sat_hi - XW'(1);
		q_pos  = XW'({1'b0, in_word.quo});
		q_val  = in_word.side.neg ? -q_pos : q_pos;
		// zero step saturates toward the sign of the coefficient; a zero coefficient gives zero
		priority if (in_word.side.zero_step) begin
			q_sat = in_word.side.coef_zero ? '0 : (in_word.side.neg ? sat_lo : sat_hi);
		end else if (q_val > sat_hi) begin
			q_sat = sat_hi;
		end else if (q_val < sat_lo) begin
			q_sat = sat_lo;
		end else begin
			q_sat = q_val;
		end
		q_cw     = q_sat[COEF_WIDTH-1:0];
		prev_ext = XW'($signed(in_word.side.prev_ref));
		prev_cw  = prev_ext[COEF_WIDTH-1:0];
	end

	// predictor lookup, out-of-range select reads as zero
	always_comb begin
		pred_rd = '0;
		for (int i = 0; i < NUM_DC_PREDICTORS; i++) begin
			if (SELX'(in_word.side.sel) == SELX'(i)) begin
				pred_rd = pred_q[i];
			end
		end
		pred_ok = SELX'(in_word.side.sel) < SELX'(NUM_DC_PREDICTORS);
		pred_wr = load && !in_word.side.kind && in_word.side.is_dc && pred_ok;
	end

	always_comb begin
		priority if (in_word.side.kind) begin
			coded_cw = q_cw - prev_cw;
		end else if (in_word.side.is_dc) begin
			coded_cw = q_cw - pred_rd;
		end else begin
			coded_cw = q_cw;
		end
		coded_ext = XW'(coded_cw);
		q_ext     = XW'(q_cw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pred_q      <= '0;
		end else begin
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
			for (int i = 0; i < NUM_DC_PREDICTORS; i++) begin
				if (pred_wr && SELX'(in_word.side.sel) == SELX'(i)) begin
					pred_q[i] <= q_cw;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			coded_q <= coded_ext[FIELD_W-1:0];
			ref_q   <= q_ext[FIELD_W-1:0];
			kind_q  <= in_word.side.kind;
			dc_q    <= in_word.side.is_dc;
		end
	end

	assign out_valid       = out_valid_q;
	assign coded_value     = coded_q;
	assign reference_value = ref_q;

	// the divider never yields more than 32768 for a nonzero step
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_word.side.zero_step |-> in_word.quo <= DIVW'(32768))
		else $error("quotient out of range");

	// predictors move only on an accepted intra dc word
	a_pred_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && !in_word.side.kind && in_word.side.is_dc) |=> $stable(pred_q))
		else $error("dc predictor changed unexpectedly");

	// intra ac words carry the quantized value unchanged
	a_ac_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !kind_q && !dc_q |-> coded_q == ref_q)
		else $error("intra ac coded value differs from reference");

endmodule

`default_nettype wire
